// ===== rtl/core/amd_pkg.sv =====
// shared types, constants and threshold mapping for the motion detector
package amd_pkg;

	// field widths
	localparam int unsigned ACCEL_W  = 16;
	localparam int unsigned SENS_W   = 7;
	localparam int unsigned DEV_W    = 18;
	localparam int unsigned THRESH_W = 12;
	localparam int unsigned AXES     = 3;

	// threshold = sensitivity * THRESH_SCALE / PERCENT_FULL, truncated
	localparam int unsigned THRESH_SCALE = 2048;
	localparam int unsigned PERCENT_FULL = 100;

	// reciprocal for the divide by PERCENT_FULL, exact for every scaled value
	localparam int unsigned SCALED_W     = SENS_W + $clog2(THRESH_SCALE);
	localparam int unsigned PCT_LOG      = $clog2(PERCENT_FULL);
	localparam int unsigned THRESH_SH    = SCALED_W + PCT_LOG;
	localparam int unsigned PCT_RECIP_W  = SCALED_W + 1;
	localparam logic [PCT_RECIP_W-1:0] PCT_RECIP =
		PCT_RECIP_W'(((64'd1 << THRESH_SH) + PERCENT_FULL - 1) / PERCENT_FULL);

	// queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = 1;
	localparam int unsigned QCNT_W = 2;

	// one three-axis sample
	typedef struct packed {
		logic signed [ACCEL_W-1:0] x;
		logic signed [ACCEL_W-1:0] y;
		logic signed [ACCEL_W-1:0] z;
	} sample_t;

	localparam int unsigned SAMPLE_W = $bits(sample_t);

	// map a sensitivity percent to the deviation threshold
	function automatic logic [THRESH_W-1:0] sens_to_thresh(input logic [SENS_W-1:0] sens);
		logic [SCALED_W-1:0]             scaled;
		logic [SCALED_W+PCT_RECIP_W-1:0] prod;
		scaled = SCALED_W'(sens) << $clog2(THRESH_SCALE);
		prod   = (SCALED_W+PCT_RECIP_W)'(scaled) * (SCALED_W+PCT_RECIP_W)'(PCT_RECIP);
		return prod[THRESH_SH +: THRESH_W];
	endfunction

endpackage

// ===== rtl/core/amd_if.sv =====
// stream and configuration interfaces of the motion detector

// input sample channel
interface amd_sample_if
	import amd_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [ACCEL_W-1:0] accel_x;
	logic signed [ACCEL_W-1:0] accel_y;
	logic signed [ACCEL_W-1:0] accel_z;

	modport source(output valid, output accel_x, output accel_y, output accel_z, input ready);
	modport sink(input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

// result channel
interface amd_result_if
	import amd_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [DEV_W-1:0] deviation_sum;
	logic             moved;

	modport source(output valid, output deviation_sum, output moved, input ready);
	modport sink(input valid, input deviation_sum, input moved, output ready);
endinterface

// sensitivity write channel
interface amd_cfg_if
	import amd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [SENS_W-1:0] data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/amd_front.sv =====
// front end: sample window shift line and running per-axis sums
module amd_front
	import amd_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = 8,
	parameter int unsigned SUM_W        = ACCEL_W + $clog2(WINDOW_DEPTH),
	parameter int unsigned ITEM_W       = AXES * SUM_W + SAMPLE_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sample_t           in_sample,
	output logic              push_valid,
	input  logic              push_ready,
	output logic [ITEM_W-1:0] push_item
);

	localparam int unsigned EXT_W = SUM_W - ACCEL_W;
	localparam logic signed [SUM_W-1:0] DEPTH_S = SUM_W'(WINDOW_DEPTH);

	sample_t                  win_q [WINDOW_DEPTH];
	logic signed [SUM_W-1:0]  sum_q [AXES];
	logic signed [SUM_W-1:0]  sum_nxt [AXES];
	logic signed [ACCEL_W-1:0] cur_a [AXES];
	logic signed [ACCEL_W-1:0] old_a [AXES];
	logic                     primed_q;
	logic                     accept;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	assign cur_a[0] = in_sample.x;
	assign cur_a[1] = in_sample.y;
	assign cur_a[2] = in_sample.z;
	assign old_a[0] = win_q[WINDOW_DEPTH-1].x;
	assign old_a[1] = win_q[WINDOW_DEPTH-1].y;
	assign old_a[2] = win_q[WINDOW_DEPTH-1].z;

	// new window sums: first beat fills the window, later beats replace the oldest
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			if (!primed_q) begin
				sum_nxt[a] = {{EXT_W{cur_a[a][ACCEL_W-1]}}, cur_a[a]} * DEPTH_S;
			end else begin
				sum_nxt[a] = sum_q[a] + {{EXT_W{cur_a[a][ACCEL_W-1]}}, cur_a[a]}
					- {{EXT_W{old_a[a][ACCEL_W-1]}}, old_a[a]};
			end
		end
	end

	assign push_item = {sum_nxt[0], sum_nxt[1], sum_nxt[2], in_sample};

	// primed flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
		end else if (accept) begin
			primed_q <= 1'b1;
		end
	end

	// window shift line and running sums
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= sum_nxt[a];
			end
			if (!primed_q) begin
				for (int i = 0; i < WINDOW_DEPTH; i++) begin
					win_q[i] <= in_sample;
				end
			end else begin
				win_q[0] <= in_sample;
				for (int i = 1; i < WINDOW_DEPTH; i++) begin
					win_q[i] <= win_q[i-1];
				end
			end
		end
	end

endmodule

// ===== rtl/core/amd_queue.sv =====
// two-entry queue between front and back
module amd_queue
	import amd_pkg::*;
#(
	parameter int unsigned ITEM_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [ITEM_W-1:0] push_item,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [ITEM_W-1:0] pop_item
);

	logic [ITEM_W-1:0] mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/core/amd_back.sv =====
// back end: window average by reciprocal multiply, deviation and threshold compare
module amd_back
	import amd_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = 8,
	parameter int unsigned SUM_W        = ACCEL_W + $clog2(WINDOW_DEPTH),
	parameter int unsigned ITEM_W       = AXES * SUM_W + SAMPLE_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  logic [ITEM_W-1:0]   pop_item,
	input  logic [THRESH_W-1:0] thresh,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DEV_W-1:0]    out_dev,
	output logic                out_moved
);

	// exact divide by the window depth for magnitudes below 2**MAG_W
	localparam int unsigned LOG_D   = $clog2(WINDOW_DEPTH);
	localparam int unsigned MAG_W   = SUM_W;
	localparam int unsigned SH      = MAG_W + LOG_D;
	localparam int unsigned RECIP_W = MAG_W + 1;
	localparam int unsigned PROD_W  = MAG_W + RECIP_W;
	localparam int unsigned AVG_W   = ACCEL_W + 1;
	localparam int unsigned DIFF_W  = ACCEL_W + 2;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SH) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);

	logic signed [SUM_W-1:0]   in_sum [AXES];
	sample_t                   in_cur;

	logic                      s1_v;
	logic [MAG_W-1:0]          mag_s1 [AXES];
	logic                      neg_s1 [AXES];
	sample_t                   cur_s1;

	logic                      s2_v;
	logic signed [AVG_W-1:0]   avg_s2 [AXES];
	sample_t                   cur_s2;

	logic [PROD_W-1:0]         prod [AXES];
	logic [AVG_W-1:0]          quot [AXES];
	logic signed [ACCEL_W-1:0] cur_a [AXES];
	logic signed [DIFF_W-1:0]  diff [AXES];
	logic [AVG_W-1:0]          adiff [AXES];
	logic [DEV_W-1:0]          dev;

	logic                      out_adv;
	logic                      s2_free;
	logic                      s1_free;
	logic [DEV_W-1:0]          dev_q;
	logic                      moved_q;
	logic                      out_v_q;

	// unpack the queue entry
	assign in_sum[0] = pop_item[SAMPLE_W + 2*SUM_W +: SUM_W];
	assign in_sum[1] = pop_item[SAMPLE_W + SUM_W +: SUM_W];
	assign in_sum[2] = pop_item[SAMPLE_W +: SUM_W];
	assign in_cur    = pop_item[SAMPLE_W-1:0];

	// stage handshake
	assign out_adv   = !out_v_q || out_ready;
	assign s2_free   = !s2_v || out_adv;
	assign s1_free   = !s1_v || s2_free;
	assign pop_ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v    <= 1'b0;
			s2_v    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_v <= pop_valid;
			end
			if (s2_free) begin
				s2_v <= s1_v;
			end
			if (out_adv) begin
				out_v_q <= s2_v;
			end
		end
	end

	// stage 1: sign and magnitude of the window sums
	always_ff @(posedge clk) begin
		if (s1_free && pop_valid) begin
			for (int a = 0; a < AXES; a++) begin
				neg_s1[a] <= in_sum[a][SUM_W-1];
				mag_s1[a] <= in_sum[a][SUM_W-1] ? MAG_W'(-in_sum[a]) : MAG_W'(in_sum[a]);
			end
			cur_s1 <= in_cur;
		end
	end

	// stage 2: average, truncated toward zero
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			prod[a] = PROD_W'(mag_s1[a]) * PROD_W'(RECIP);
			quot[a] = prod[a][SH +: AVG_W];
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_v) begin
			for (int a = 0; a < AXES; a++) begin
				avg_s2[a] <= neg_s1[a] ? -signed'(quot[a]) : signed'(quot[a]);
			end
			cur_s2 <= cur_s1;
		end
	end

	// stage 3: absolute deviations, their sum and the compare
	assign cur_a[0] = cur_s2.x;
	assign cur_a[1] = cur_s2.y;
	assign cur_a[2] = cur_s2.z;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			diff[a]  = DIFF_W'(avg_s2[a]) - DIFF_W'(cur_a[a]);
			adiff[a] = diff[a][DIFF_W-1] ? AVG_W'(-diff[a]) : AVG_W'(diff[a]);
		end
		dev = DEV_W'(adiff[0]) + DEV_W'(adiff[1]) + DEV_W'(adiff[2]);
	end

	always_ff @(posedge clk) begin
		if (out_adv && s2_v) begin
			dev_q   <= dev;
			moved_q <= (dev > DEV_W'(thresh));
		end
	end

	assign out_valid = out_v_q;
	assign out_dev   = dev_q;
	assign out_moved = moved_q;

endmodule

// ===== rtl/core/accel_motion_detector_core.sv =====
// top level of the accelerometer motion detector
//
//  channel  dir  beat contents
//  -------  ---  -----------------------------------------------
//  sample   in   accel_x, accel_y, accel_z (signed 16 bit each)
//  result   out  deviation_sum (18 bit), moved (1 bit)
//  cfg      in   data: sensitivity percent (7 bit)
//
// one sample beat per cycle sustained while result is ready; each beat's result passes
// through the queue entry written at the accepting edge, then the magnitude, average and output stages
// the window is a shift line with running sums, so depth does not cost cycles
// arst_n clears the primed flag, queue and stage valids; threshold resets to zero
// result stalls back up through the back stages and the queue to sample.ready
module accel_motion_detector_core
	import amd_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	amd_sample_if.sink   sample,
	amd_result_if.source result,
	amd_cfg_if.sink      cfg
);

	localparam int unsigned SUM_W  = ACCEL_W + $clog2(WINDOW_DEPTH);
	localparam int unsigned ITEM_W = AXES * SUM_W + SAMPLE_W;

	sample_t             in_sample;
	logic                push_valid;
	logic                push_ready;
	logic [ITEM_W-1:0]   push_item;
	logic                pop_valid;
	logic                pop_ready;
	logic [ITEM_W-1:0]   pop_item;
	logic [THRESH_W-1:0] thresh_q;

	assign in_sample = '{x: sample.accel_x, y: sample.accel_y, z: sample.accel_z};

	// threshold register, mapped from sensitivity at write time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
		end else if (cfg.valid) begin
			thresh_q <= sens_to_thresh(cfg.data);
		end
	end

	amd_front #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.SUM_W       (SUM_W),
		.ITEM_W      (ITEM_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.in_sample (in_sample),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	amd_queue #(
		.ITEM_W(ITEM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	amd_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.SUM_W       (SUM_W),
		.ITEM_W      (ITEM_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item (pop_item),
		.thresh   (thresh_q),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.out_dev  (result.deviation_sum),
		.out_moved(result.moved)
	);

endmodule
